/* rtl/core/cmg_pkg.sv */
package cmg_pkg;

    localparam int FRAC_BITS     = 8;
    localparam int MAX_DIVISIONS = 256;
    localparam int CNT_W         = $clog2(MAX_DIVISIONS + 1);
    // sine / cosine magnitude, 1.0 plus headroom
    localparam int MAG_W         = FRAC_BITS + 2;

    localparam logic [7:0] REG_RADIUS = 8'd0;
    localparam logic [7:0] REG_HEIGHT = 8'd1;
    localparam logic [7:0] REG_SLICES = 8'd2;
    localparam logic [7:0] REG_STACKS = 8'd3;

    typedef struct packed {
        logic base;
        logic zero;
        logic last;
        logic err;
    } cmg_flag_t;

    typedef struct packed {
        logic [15:0] rad;
        logic [15:0] ht;
        cmg_flag_t   flag;
    } cmg_side_t;

    typedef struct packed {
        logic [MAG_W-1:0] smag;
        logic             sneg;
        logic [MAG_W-1:0] cmag;
        logic             cneg;
    } cmg_trig_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [7:0] c);
        return (CNT_W'(c) > CNT_W'(MAX_DIVISIONS)) ? CNT_W'(MAX_DIVISIONS) : CNT_W'(c);
    endfunction

endpackage

/* rtl/core/cone_mesh_cell_generator_top.sv */
// Channel   Dir  Handshake                Payload
// s_        in   s_tvalid / s_tready      slice_index, band_index (tdata), base_cap (tuser)
// m_        out  m_tvalid / m_tready      vert_x, vert_y, vert_z (tdata), last_vertex (tlast),
//                                         index_error (tuser)
// cfg_      in   cfg_valid / cfg_ready    register index, write data
//
// One vertex leaves per cycle unless m_tready stalls the pipeline: a request expands to six
// vertices for a side band, three for the base or the top band, one when rejected.
// The vertex expander at the head does this; vertices then pass 17 divider steps, 34 trig stages.
// aresetn is synchronous; it clears valid bits and loads the default cone.
// With m_tvalid high, m_tready low freezes every stage; s_tready follows in the same cycle.
module cone_mesh_cell_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] slice_index, [15:8] band_index
    input  logic        s_tuser,   // [0] base_cap
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [16:0] vert_x, [32:17] vert_y, [49:33] vert_z, zero pad
    output logic        m_tlast,
    output logic        m_tuser,   // [0] index_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DW     = 28;
    localparam int DIV_Q  = 17;
    localparam int CW     = cmg_pkg::CNT_W;
    localparam int PROD_W = 16 + cmg_pkg::MAG_W;

    // configuration
    logic [15:0] cone_radius_reg, cone_height_reg;
    logic [7:0]  slice_count_reg, stack_count_reg;
    logic [CW-1:0] cnt_s, cnt_t;

    assign cfg_ready = 1'b1;
    assign cnt_s     = cmg_pkg::clamp_count(slice_count_reg);
    assign cnt_t     = cmg_pkg::clamp_count(stack_count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cone_radius_reg <= 16'd512;
            cone_height_reg <= 16'd1280;
            slice_count_reg <= 8'd30;
            stack_count_reg <= 8'd30;
        end else if (cfg_valid) begin
            case (cfg_index)
                cmg_pkg::REG_RADIUS: cone_radius_reg <= cfg_data;
                cmg_pkg::REG_HEIGHT: cone_height_reg <= cfg_data;
                cmg_pkg::REG_SLICES: slice_count_reg <= cfg_data[7:0];
                cmg_pkg::REG_STACKS: stack_count_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic m_valid_reg;

    assign en = !m_valid_reg || m_tready;

    // vertex expander
    logic       busy_reg;
    logic [2:0] cnt_reg;
    logic [7:0] item_slice_reg, item_band_reg;
    logic       item_base_reg;
    logic       item_err, top_band, cur_last, cur_zero;
    logic [CW-1:0] i_a, i_b, j_a, j_b, v_k, v_jj;

    assign i_a      = CW'(item_slice_reg);
    assign i_b      = CW'(item_slice_reg) + CW'(1);
    assign j_a      = CW'(item_band_reg);
    assign j_b      = CW'(item_band_reg) + CW'(1);
    assign item_err = (i_a >= cnt_s) || (!item_base_reg && (j_a >= cnt_t));
    assign top_band = (j_b == cnt_t);
    assign cur_zero = item_err || (item_base_reg && (cnt_reg == 3'd0));

    always_comb begin
        if (item_err) begin
            cur_last = 1'b1;
        end else if (item_base_reg || top_band) begin
            cur_last = (cnt_reg == 3'd2);
        end else begin
            cur_last = (cnt_reg == 3'd5);
        end
    end

    // side order: upper-a, lower-a, lower-b, upper-a, lower-b, upper-b
    always_comb begin
        if (item_base_reg) begin
            v_jj = '0;
            v_k  = (cnt_reg == 3'd1) ? i_b : i_a;
        end else begin
            case (cnt_reg)
                3'd0: begin v_k = i_a; v_jj = j_b; end
                3'd1: begin v_k = i_a; v_jj = j_a; end
                3'd2: begin v_k = i_b; v_jj = j_a; end
                3'd3: begin v_k = i_a; v_jj = j_b; end
                3'd4: begin v_k = i_b; v_jj = j_a; end
                default: begin v_k = i_b; v_jj = j_b; end
            endcase
        end
    end

    assign s_tready = en && (!busy_reg || cur_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else if (en) begin
            if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cur_last) begin
                    busy_reg <= 1'b0;
                end
            end
            if (s_tvalid && s_tready) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_slice_reg <= s_tdata[7:0];
            item_band_reg  <= s_tdata[15:8];
            item_base_reg  <= s_tuser;
        end
    end

    // vertex request register
    logic               a_valid_reg;
    logic [CW-1:0]      a_k_reg, a_jj_reg;
    cmg_pkg::cmg_flag_t a_flag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_k_reg    <= v_k;
            a_jj_reg   <= v_jj;
            a_flag_reg <= '{base: item_base_reg, zero: cur_zero, last: cur_last, err: item_err};
        end
    end

    // dividends: phase k*2^16 / S, radius and height rounded ratios over 2T
    logic [CW:0]   tmj;
    logic [25:0]   rprod, hprod;
    logic [DW-1:0] num [3];
    logic [DW-1:0] div_d [3];

    assign tmj    = (CW+1)'(cnt_t) - (CW+1)'(a_jj_reg);
    assign rprod  = 26'(cone_radius_reg) * 26'(tmj);
    assign hprod  = 26'(cone_height_reg) * 26'(a_jj_reg);
    assign num[0] = DW'({a_k_reg, 16'd0});
    assign num[1] = {1'b0, rprod, 1'b0} + DW'(cnt_t);
    assign num[2] = {1'b0, hprod, 1'b0} + DW'(cnt_t);
    assign div_d[0] = DW'(cnt_s);
    assign div_d[1] = DW'({cnt_t, 1'b0});
    assign div_d[2] = DW'({cnt_t, 1'b0});

    // restoring dividers, one quotient bit per stage
    logic [DW-1:0]    rem_reg  [3][DIV_Q+1];
    logic [DIV_Q-1:0] quo_reg  [3][DIV_Q+1];
    logic [DW-1:0]    rem_next [3][DIV_Q+1];
    logic [DIV_Q-1:0] quo_next [3][DIV_Q+1];
    logic             dv_reg   [DIV_Q+1];
    cmg_pkg::cmg_flag_t dflag_reg [DIV_Q+1];

    always_comb begin
        logic [DW-1:0] dsh;
        logic          ge;
        for (int l = 0; l < 3; l++) begin
            rem_next[l][0] = num[l];
            quo_next[l][0] = '0;
            for (int n = 1; n <= DIV_Q; n++) begin
                dsh = div_d[l] << (DIV_Q - n);
                ge  = (rem_reg[l][n-1] >= dsh);
                rem_next[l][n] = ge ? (rem_reg[l][n-1] - dsh) : rem_reg[l][n-1];
                quo_next[l][n] = quo_reg[l][n-1] | (DIV_Q'(ge) << (DIV_Q - n));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n <= DIV_Q; n++) begin
                dv_reg[n] <= 1'b0;
            end
        end else if (en) begin
            dv_reg[0] <= a_valid_reg;
            for (int n = 1; n <= DIV_Q; n++) begin
                dv_reg[n] <= dv_reg[n-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dflag_reg[0] <= a_flag_reg;
            for (int n = 1; n <= DIV_Q; n++) begin
                dflag_reg[n] <= dflag_reg[n-1];
            end
            for (int l = 0; l < 3; l++) begin
                for (int n = 0; n <= DIV_Q; n++) begin
                    rem_reg[l][n] <= rem_next[l][n];
                    quo_reg[l][n] <= quo_next[l][n];
                end
            end
        end
    end

    // sine / cosine
    cmg_pkg::cmg_side_t div_side, tr_side;
    cmg_pkg::cmg_trig_t tr_trig;
    logic               tr_valid;

    // base cells sit at y = 0 with the full radius, whatever the stack count
    assign div_side.rad  = dflag_reg[DIV_Q].base ? cone_radius_reg : quo_reg[1][DIV_Q][15:0];
    assign div_side.ht   = dflag_reg[DIV_Q].base ? 16'd0 : quo_reg[2][DIV_Q][15:0];
    assign div_side.flag = dflag_reg[DIV_Q];

    cmg_trig u_trig (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_reg[DIV_Q]),
        .in_phase  (quo_reg[0][DIV_Q][15:0]),
        .in_side   (div_side),
        .out_valid (tr_valid),
        .out_trig  (tr_trig),
        .out_side  (tr_side)
    );

    // scale by band radius
    logic               e_valid_reg;
    logic [PROD_W-1:0]  e_px_reg, e_pz_reg;
    logic               e_sneg_reg, e_cneg_reg;
    logic [15:0]        e_ht_reg;
    cmg_pkg::cmg_flag_t e_flag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= tr_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_px_reg   <= PROD_W'(tr_side.rad) * PROD_W'(tr_trig.smag);
            e_pz_reg   <= PROD_W'(tr_side.rad) * PROD_W'(tr_trig.cmag);
            e_sneg_reg <= tr_trig.sneg;
            e_cneg_reg <= tr_trig.cneg;
            e_ht_reg   <= tr_side.ht;
            e_flag_reg <= tr_side.flag;
        end
    end

    localparam logic [PROD_W:0] HALF = (PROD_W+1)'(1) << (cmg_pkg::FRAC_BITS - 1);

    logic [16:0] vx, vz, x_next, z_next;

    assign vx     = 17'(((PROD_W+1)'(e_px_reg) + HALF) >> cmg_pkg::FRAC_BITS);
    assign vz     = 17'(((PROD_W+1)'(e_pz_reg) + HALF) >> cmg_pkg::FRAC_BITS);
    assign x_next = e_flag_reg.zero ? 17'd0 : (e_sneg_reg ? 17'd0 - vx : vx);
    assign z_next = e_flag_reg.zero ? 17'd0 : (e_cneg_reg ? 17'd0 - vz : vz);

    // output register
    logic [16:0] m_x_reg, m_z_reg;
    logic [15:0] m_y_reg;
    logic        m_last_reg, m_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_x_reg    <= x_next;
            m_y_reg    <= e_flag_reg.zero ? 16'd0 : e_ht_reg;
            m_z_reg    <= z_next;
            m_last_reg <= e_flag_reg.last;
            m_err_reg  <= e_flag_reg.err;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_z_reg, m_y_reg, m_x_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

endmodule

/* rtl/core/cmg_trig.sv */
module cmg_trig (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [15:0]         in_phase,
    input  cmg_pkg::cmg_side_t  in_side,
    output logic                out_valid,
    output cmg_pkg::cmg_trig_t  out_trig,
    output cmg_pkg::cmg_side_t  out_side
);

    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [30:0] ONE    = 31'h4000_0000;
    localparam int          NITER  = 6;

    localparam logic [7:0] TAYLOR_DIV [2][6] = '{
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6},
        '{8'd132, 8'd90,  8'd56, 8'd30, 8'd12, 8'd2}
    };
    // floor(2^40 / d): quotient estimate is exact or one low
    localparam logic [39:0] TAYLOR_RECIP [2][6] = '{
        '{40'((64'd1 << 40) / 64'd156), 40'((64'd1 << 40) / 64'd110),
          40'((64'd1 << 40) / 64'd72),  40'((64'd1 << 40) / 64'd42),
          40'((64'd1 << 40) / 64'd20),  40'((64'd1 << 40) / 64'd6)},
        '{40'((64'd1 << 40) / 64'd132), 40'((64'd1 << 40) / 64'd90),
          40'((64'd1 << 40) / 64'd56),  40'((64'd1 << 40) / 64'd30),
          40'((64'd1 << 40) / 64'd12),  40'((64'd1 << 40) / 64'd2)}
    };

    typedef struct packed {
        logic [1:0]         quad;
        logic [30:0]        x;
        logic [31:0]        x2;
        cmg_pkg::cmg_side_t side;
    } carry_t;

    function automatic logic [cmg_pkg::MAG_W-1:0] quant(input logic [30:0] v);
        logic [31:0] s;
        s = 32'(v) + (32'd1 << (29 - cmg_pkg::FRAC_BITS));
        return cmg_pkg::MAG_W'(s >> (30 - cmg_pkg::FRAC_BITS));
    endfunction

    // angle setup
    logic               t0_valid_reg, t1_valid_reg;
    logic [1:0]         t0_quad_reg;
    logic [30:0]        t0_x_reg;
    cmg_pkg::cmg_side_t t0_side_reg;
    carry_t             t1_carry_reg;
    logic [45:0]        xprod;
    logic [61:0]        x2prod;

    assign xprod  = 46'(in_phase[13:0]) * 46'(PI_Q30);
    assign x2prod = 62'(t0_x_reg) * 62'(t0_x_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_valid_reg <= 1'b0;
            t1_valid_reg <= 1'b0;
        end else if (en) begin
            t0_valid_reg <= in_valid;
            t1_valid_reg <= t0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_quad_reg       <= in_phase[15:14];
            t0_x_reg          <= xprod[45:15];
            t0_side_reg       <= in_side;
            t1_carry_reg.quad <= t0_quad_reg;
            t1_carry_reg.x    <= t0_x_reg;
            t1_carry_reg.x2   <= x2prod[61:30];
            t1_carry_reg.side <= t0_side_reg;
        end
    end

    // Taylor terms, five stages per term, sine in lane 0 and cosine in lane 1
    carry_t      it_c [NITER+1];
    logic        it_v [NITER+1];
    logic [30:0] it_t [NITER+1][2];

    assign it_c[0]    = t1_carry_reg;
    assign it_v[0]    = t1_valid_reg;
    assign it_t[0][0] = ONE;
    assign it_t[0][1] = ONE;

    for (genvar g = 0; g < NITER; g++) begin : g_term
        carry_t      cv_reg [5];
        logic        vv_reg [5];
        logic [31:0] p_reg  [2];
        logic [31:0] p1_reg [2];
        logic [31:0] p2_reg [2];
        logic [51:0] hi_reg [2];
        logic [51:0] lo_reg [2];
        logic [31:0] qe_reg [2];
        logic [31:0] qe3_reg[2];
        logic [31:0] rem_reg[2];
        logic [30:0] t_reg  [2];
        logic [62:0] mprod  [2];
        logic [71:0] qsum   [2];
        logic [39:0] qd     [2];
        logic [31:0] qfix   [2];

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                mprod[l] = 63'(it_c[g].x2) * 63'(it_t[g][l]);
                qsum[l]  = {hi_reg[l], 20'd0} + 72'(lo_reg[l]);
                qd[l]    = 40'(qe_reg[l]) * 40'(TAYLOR_DIV[l][g]);
                qfix[l]  = qe3_reg[l] + 32'(rem_reg[l] >= 32'(TAYLOR_DIV[l][g]));
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                for (int k = 0; k < 5; k++) begin
                    vv_reg[k] <= 1'b0;
                end
            end else if (en) begin
                vv_reg[0] <= it_v[g];
                for (int k = 1; k < 5; k++) begin
                    vv_reg[k] <= vv_reg[k-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                cv_reg[0] <= it_c[g];
                for (int k = 1; k < 5; k++) begin
                    cv_reg[k] <= cv_reg[k-1];
                end
                for (int l = 0; l < 2; l++) begin
                    p_reg[l]   <= mprod[l][61:30];
                    hi_reg[l]  <= 52'(p_reg[l]) * 52'(TAYLOR_RECIP[l][g][39:20]);
                    lo_reg[l]  <= 52'(p_reg[l]) * 52'(TAYLOR_RECIP[l][g][19:0]);
                    p1_reg[l]  <= p_reg[l];
                    qe_reg[l]  <= qsum[l][71:40];
                    p2_reg[l]  <= p1_reg[l];
                    rem_reg[l] <= p2_reg[l] - qd[l][31:0];
                    qe3_reg[l] <= qe_reg[l];
                    t_reg[l]   <= (qfix[l] >= 32'(ONE)) ? 31'd0 : 31'(32'(ONE) - qfix[l]);
                end
            end
        end

        assign it_c[g+1]    = cv_reg[4];
        assign it_v[g+1]    = vv_reg[4];
        assign it_t[g+1][0] = t_reg[0];
        assign it_t[g+1][1] = t_reg[1];
    end

    // sine = x * series, then quantize and fold quadrants
    logic               f0_valid_reg, f1_valid_reg;
    carry_t             f0_carry_reg;
    logic [30:0]        f0_sp_reg, f0_tc_reg;
    cmg_pkg::cmg_trig_t f1_trig_reg;
    cmg_pkg::cmg_side_t f1_side_reg;
    logic [61:0]        sprod;
    logic [cmg_pkg::MAG_W-1:0] sq, cq;
    cmg_pkg::cmg_trig_t trig_next;

    assign sprod = 62'(it_c[NITER].x) * 62'(it_t[NITER][0]);
    assign sq    = quant(f0_sp_reg);
    assign cq    = quant(f0_tc_reg);

    always_comb begin
        case (f0_carry_reg.quad)
            2'd0: trig_next = '{smag: sq, sneg: 1'b0, cmag: cq, cneg: 1'b0};
            2'd1: trig_next = '{smag: cq, sneg: 1'b0, cmag: sq, cneg: 1'b1};
            2'd2: trig_next = '{smag: sq, sneg: 1'b1, cmag: cq, cneg: 1'b1};
            default: trig_next = '{smag: cq, sneg: 1'b1, cmag: sq, cneg: 1'b0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
        end else if (en) begin
            f0_valid_reg <= it_v[NITER];
            f1_valid_reg <= f0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f0_carry_reg <= it_c[NITER];
            f0_sp_reg    <= sprod[60:30];
            f0_tc_reg    <= it_t[NITER][1];
            f1_trig_reg  <= trig_next;
            f1_side_reg  <= f0_carry_reg.side;
        end
    end

    assign out_valid = f1_valid_reg;
    assign out_trig  = f1_trig_reg;
    assign out_side  = f1_side_reg;

endmodule
